// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_CLK_NR(label, clk, prop, msg)
`endif
`endif

// ===== hdl/fsf_pkg.sv =====
// ----------------------------------------------------------------------------
// fsf_pkg: shared types and constants
// Command codes, register indexes, sequencer states and unit control struct.
// ----------------------------------------------------------------------------
`default_nettype none
package fsf_pkg;
  localparam int MaxFrames = 64;
  localparam int SlotW = $clog2(MaxFrames);

  localparam logic [3:0] CMD_TICK    = 4'd0;
  localparam logic [3:0] CMD_PLAY    = 4'd1;
  localparam logic [3:0] CMD_STOP    = 4'd2;
  localparam logic [3:0] CMD_PAUSE   = 4'd3;
  localparam logic [3:0] CMD_RESUME  = 4'd4;
  localparam logic [3:0] CMD_SPEED   = 4'd5;
  localparam logic [3:0] CMD_OPACITY = 4'd6;
  localparam logic [3:0] CMD_FADEIN  = 4'd7;
  localparam logic [3:0] CMD_FADEOUT = 4'd8;
  localparam logic [3:0] CMD_CLRFADE = 4'd9;
  localparam logic [3:0] CMD_FLIP    = 4'd10;
  localparam logic [3:0] CMD_LOADDUR = 4'd11;

  localparam logic [1:0] REG_FRAME_COUNT = 2'd0;
  localparam logic [1:0] REG_LOOP_ENABLE = 2'd1;
  localparam logic [1:0] REG_END_REWIND  = 2'd2;
  localparam logic [1:0] REG_CLIP_SPEED  = 2'd3;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [15:0] tick_dt;
    logic        restart;
    logic        from_zero;
    logic [15:0] value;
    logic [5:0]  frame_slot;
    logic        flip_h;
    logic        flip_v;
  } in_item_t;

  typedef struct packed {
    logic [5:0] frame_index;
    logic [7:0] alpha;
    logic       visible;
    logic       mirror_h;
    logic       mirror_v;
    logic       playing;
    logic       paused;
    logic       finished;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CMD, S_FADE_MUL, S_FADE_DIV, S_FADE_END, S_RATE, S_SCALE,
    S_ADD, S_SUM, S_STEP, S_MOD, S_ALPHA, S_OUT
  } state_t;

  // Request to the shared divider.
  typedef struct packed {
    logic        start;
    logic [47:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic        busy;
    logic [47:0] quo;
    logic [31:0] rem;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== hdl/fsf_if.sv =====
// ----------------------------------------------------------------------------
// fsf_if: valid/ready channel
// Generic handshake channel carrying one payload type.
// ----------------------------------------------------------------------------
`default_nettype none
interface fsf_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/fsf_div.sv =====
// ----------------------------------------------------------------------------
// fsf_div: shared restoring divider
// Divides a 48-bit numerator by a 32-bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module fsf_div (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire fsf_pkg::div_req_t req,
  output fsf_pkg::div_rsp_t    rsp
);
  logic [47:0] quo;
  logic [32:0] rem;
  logic [31:0] den;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem[31:0], quo[47]};
  assign diff = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 6'd48;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.num;
      rem <= '0;
      den <= req.den;
    end else if (busy) begin
      if (!diff[32]) begin
        rem <= diff;
        quo <= {quo[46:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[46:0], 1'b0};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.busy = busy;
  assign rsp.quo = quo;
  assign rsp.rem = rem[31:0];

  `ASSERT_CLK(a_no_restart, clk, rst, busy |-> !req.start, "divider restarted while busy")
  `ASSERT_CLK(a_done_after_busy, clk, rst, done |-> $past(busy), "done without work")
  `ASSERT_CLK(a_done_idle, clk, rst, done |-> !busy, "done while busy")
endmodule
`default_nettype wire

// ===== hdl/fsf_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsf_ctrl: command sequencer
// Holds play state, steps commands; fades and loop wraps use the shared divider.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module fsf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  fsf_if.sink                     in_ch,
  fsf_if.source                   out_ch,
  fsf_if.sink                     cfg_ch,
  output fsf_pkg::div_req_t       dreq,
  input  wire fsf_pkg::div_rsp_t  drsp
);
  localparam int SW = fsf_pkg::SlotW;
  localparam int CW = SW + 1;

  fsf_pkg::state_t state, state_next;
  fsf_pkg::in_item_t it;

  logic [6:0]  frame_count;
  logic        loop_enable, end_rewind;
  logic [15:0] clip_rate;

  logic [15:0] durs [fsf_pkg::MaxFrames];
  logic [15:0] dur_rd;
  logic [SW-1:0] rd_addr;

  logic [SW-1:0] cur;
  logic [31:0] elapsed;
  logic [15:0] run_speed, opacity, fade_from, fade_to, fade_len, fade_prog;
  logic playing, paused, finished, fading, mir_h, mir_v, loaded;

  logic [31:0] prod;
  logic [47:0] scaled;
  logic [31:0] total;
  logic [CW-1:0] sum_idx;
  logic [15:0] part_len;
  logic [7:0] alpha;
  logic       div_busy_wait;
  fsf_pkg::out_item_t res;

  logic [CW-1:0] count;
  logic [CW-1:0] cur_ext;
  logic          valid_frame;
  logic [15:0]   dur_eff;
  logic [16:0]   prog_sum;
  logic [15:0]   prog_new;
  logic [15:0]   span;
  logic [32:0]   elapsed_sum;
  logic [23:0]   alpha_num;
  logic [24:0]   alpha_acc;

  always_comb begin
    if (frame_count == 7'd0) count = CW'(1);
    else if (frame_count > 7'(fsf_pkg::MaxFrames)) count = CW'(fsf_pkg::MaxFrames);
    else count = CW'(frame_count);
  end
  assign cur_ext = {1'b0, cur};
  assign valid_frame = loaded && (cur_ext < count);
  assign dur_eff = (dur_rd == 16'd0) ? 16'd1 : dur_rd;
  assign prog_sum = {1'b0, fade_prog} + {1'b0, it.tick_dt};
  assign prog_new = (prog_sum > {1'b0, fade_len}) ? fade_len : prog_sum[15:0];
  assign span = (fade_to >= fade_from) ? fade_to - fade_from : fade_from - fade_to;
  assign elapsed_sum = {1'b0, elapsed} + {1'b0, scaled[47:16]};

  // Rounded opacity * 255 / 65535: the quotient by 65535 is taken by adding
  // the high part back in and shifting, exact while the quotient is below 2^16.
  assign alpha_num = 24'(opacity) * 24'd255 + 24'd32767;
  assign alpha_acc = {1'b0, alpha_num} + 25'(alpha_num[23:16]) + 25'd1;

  assign in_ch.ready = (state == fsf_pkg::S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (state == fsf_pkg::S_OUT);
  assign out_ch.data = res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= 7'd1;
      loop_enable <= 1'b1;
      end_rewind <= 1'b0;
      clip_rate <= 16'd256;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data.index)
        fsf_pkg::REG_FRAME_COUNT: frame_count <= cfg_ch.data.data[6:0];
        fsf_pkg::REG_LOOP_ENABLE: loop_enable <= cfg_ch.data.data[0];
        fsf_pkg::REG_END_REWIND:  end_rewind <= cfg_ch.data.data[0];
        fsf_pkg::REG_CLIP_SPEED:  clip_rate <= cfg_ch.data.data[15:0];
        default: ;
      endcase
    end
  end

  // Duration table with a registered read port.
  always_comb begin
    rd_addr = cur;
    if (state == fsf_pkg::S_SUM || state == fsf_pkg::S_ADD) rd_addr = sum_idx[SW-1:0];
  end
  always_ff @(posedge clk) begin
    if (state == fsf_pkg::S_CMD && it.cmd == fsf_pkg::CMD_LOADDUR)
      durs[it.frame_slot] <= it.value;
    dur_rd <= durs[rd_addr];
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      fsf_pkg::S_IDLE: if (in_ch.valid) state_next = fsf_pkg::S_CMD;
      fsf_pkg::S_CMD: begin
        if (it.cmd == fsf_pkg::CMD_TICK) begin
          if (fading && fade_len != 16'd0) state_next = fsf_pkg::S_FADE_MUL;
          else state_next = fsf_pkg::S_RATE;
        end else begin
          state_next = fsf_pkg::S_ALPHA;
        end
      end
      fsf_pkg::S_FADE_MUL: state_next = fsf_pkg::S_FADE_DIV;
      fsf_pkg::S_FADE_DIV: if (drsp.done) state_next = fsf_pkg::S_FADE_END;
      fsf_pkg::S_FADE_END: state_next = fsf_pkg::S_RATE;
      fsf_pkg::S_RATE: begin
        if (playing && !paused && valid_frame) state_next = fsf_pkg::S_SCALE;
        else state_next = fsf_pkg::S_ALPHA;
      end
      fsf_pkg::S_SCALE: begin
        if (prod == 32'd0) state_next = fsf_pkg::S_ALPHA;
        else state_next = fsf_pkg::S_ADD;
      end
      fsf_pkg::S_ADD: state_next = fsf_pkg::S_SUM;
      fsf_pkg::S_SUM: begin
        if (sum_idx == count) state_next = fsf_pkg::S_STEP;
      end
      fsf_pkg::S_STEP: begin
        if (div_busy_wait) state_next = fsf_pkg::S_STEP;
        else if (!valid_frame || elapsed < {16'd0, dur_eff} || !playing)
          state_next = fsf_pkg::S_ALPHA;
      end
      fsf_pkg::S_MOD: if (drsp.done) state_next = fsf_pkg::S_STEP;
      fsf_pkg::S_ALPHA: state_next = fsf_pkg::S_OUT;
      fsf_pkg::S_OUT: if (out_ch.ready) state_next = fsf_pkg::S_IDLE;
      default: state_next = fsf_pkg::S_IDLE;
    endcase
    if (state == fsf_pkg::S_STEP && !div_busy_wait && valid_frame && playing &&
        elapsed >= {16'd0, dur_eff} && cur_ext + CW'(1) >= count && loop_enable &&
        elapsed - {16'd0, dur_eff} >= total)
      state_next = fsf_pkg::S_MOD;
  end

  // Divider requests.
  always_comb begin
    dreq = '0;
    if (state == fsf_pkg::S_FADE_MUL) begin
      dreq.start = 1'b1;
      dreq.num = {16'd0, prod};
      dreq.den = {16'd0, fade_len};
    end else if (state == fsf_pkg::S_STEP && state_next == fsf_pkg::S_MOD) begin
      dreq.start = 1'b1;
      dreq.num = {16'd0, elapsed - {16'd0, dur_eff}};
      dreq.den = total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= fsf_pkg::S_IDLE;
    else state <= state_next;
  end

  // Datapath and playback state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
      elapsed <= '0;
      run_speed <= 16'd256;
      opacity <= 16'hFFFF;
      fade_from <= 16'hFFFF;
      fade_to <= 16'hFFFF;
      fade_len <= '0;
      fade_prog <= '0;
      {playing, paused, finished, fading, mir_h, mir_v, loaded} <= '0;
      div_busy_wait <= 1'b0;
      sum_idx <= '0;
      total <= '0;
    end else begin
      div_busy_wait <= 1'b0;
      case (state)
        fsf_pkg::S_IDLE: if (in_ch.valid) it <= in_ch.data;
        fsf_pkg::S_CMD: begin
          case (it.cmd)
            fsf_pkg::CMD_TICK: begin
              if (fading) begin
                if (fade_len == 16'd0) begin
                  opacity <= fade_to;
                  fading <= 1'b0;
                end else begin
                  fade_prog <= prog_new;
                  part_len <= prog_new;
                  prod <= 32'(span) * 32'(prog_new);
                end
              end
            end
            fsf_pkg::CMD_PLAY: begin
              if (it.restart || !loaded || finished) begin
                cur <= '0;
                elapsed <= '0;
                run_speed <= 16'd256;
                loaded <= 1'b1;
                playing <= 1'b1;
                paused <= 1'b0;
                finished <= 1'b0;
              end
            end
            fsf_pkg::CMD_STOP: begin
              playing <= 1'b0;
              paused <= 1'b0;
              finished <= 1'b1;
            end
            fsf_pkg::CMD_PAUSE: if (playing) paused <= 1'b1;
            fsf_pkg::CMD_RESUME: if (loaded) paused <= 1'b0;
            fsf_pkg::CMD_SPEED: run_speed <= it.value;
            fsf_pkg::CMD_OPACITY, fsf_pkg::CMD_CLRFADE: begin
              if (it.cmd == fsf_pkg::CMD_OPACITY) opacity <= it.value;
              fade_from <= (it.cmd == fsf_pkg::CMD_OPACITY) ? it.value : opacity;
              fade_to <= (it.cmd == fsf_pkg::CMD_OPACITY) ? it.value : opacity;
              fade_len <= '0;
              fade_prog <= '0;
              fading <= 1'b0;
            end
            fsf_pkg::CMD_FADEIN, fsf_pkg::CMD_FADEOUT: begin
              fade_from <= (it.cmd == fsf_pkg::CMD_FADEIN && it.from_zero) ? 16'd0 : opacity;
              fade_to <= (it.cmd == fsf_pkg::CMD_FADEIN) ? 16'hFFFF : 16'd0;
              fade_len <= it.value;
              fade_prog <= '0;
              fading <= (it.value != 16'd0);
              if (it.value == 16'd0)
                opacity <= (it.cmd == fsf_pkg::CMD_FADEIN) ? 16'hFFFF : 16'd0;
              else if (it.cmd == fsf_pkg::CMD_FADEIN && it.from_zero)
                opacity <= 16'd0;
            end
            fsf_pkg::CMD_FLIP: begin
              mir_h <= it.flip_h;
              mir_v <= it.flip_v;
            end
            default: ;
          endcase
        end
        fsf_pkg::S_FADE_DIV: begin
          if (drsp.done) begin
            if (fade_to >= fade_from) opacity <= fade_from + drsp.quo[15:0];
            else opacity <= fade_from - drsp.quo[15:0];
          end
        end
        fsf_pkg::S_FADE_END: begin
          if (part_len >= fade_len) begin
            opacity <= fade_to;
            fading <= 1'b0;
          end
        end
        fsf_pkg::S_RATE: prod <= 32'(clip_rate) * 32'(run_speed);
        fsf_pkg::S_SCALE: begin
          scaled <= 48'(prod) * 48'(it.tick_dt);
          sum_idx <= '0;
          total <= '0;
        end
        fsf_pkg::S_ADD: begin
          elapsed <= elapsed_sum[32] ? 32'hFFFFFFFF : elapsed_sum[31:0];
          sum_idx <= CW'(1);
        end
        fsf_pkg::S_SUM: begin
          // Table reads return the entry addressed in the previous cycle.
          total <= total + {16'd0, dur_eff};
          if (sum_idx != count) sum_idx <= sum_idx + CW'(1);
          else div_busy_wait <= 1'b1;
        end
        fsf_pkg::S_STEP: begin
          if (!div_busy_wait && valid_frame && playing && elapsed >= {16'd0, dur_eff}) begin
            div_busy_wait <= 1'b1;
            elapsed <= elapsed - {16'd0, dur_eff};
            if (cur_ext + CW'(1) < count) cur <= cur + SW'(1);
            else if (loop_enable) cur <= '0;
            else begin
              cur <= end_rewind ? '0 : SW'(count - CW'(1));
              playing <= 1'b0;
              finished <= 1'b1;
            end
          end
        end
        fsf_pkg::S_MOD: begin
          if (drsp.done) begin
            elapsed <= drsp.rem;
            div_busy_wait <= 1'b1;
          end
        end
        fsf_pkg::S_ALPHA: alpha <= alpha_acc[23:16];
        default: ;
      endcase
    end
  end

  assign res.frame_index = 6'(cur);
  assign res.alpha = alpha;
  assign res.visible = valid_frame && (alpha != 8'd0);
  assign res.mirror_h = mir_h;
  assign res.mirror_v = mir_v;
  assign res.playing = playing;
  assign res.paused = paused;
  assign res.finished = finished;

  `ASSERT_CLK(a_busy_no_ready, clk, rst, (state != fsf_pkg::S_IDLE) |-> !in_ch.ready, "ready while busy")
  `ASSERT_CLK(a_out_after_alpha, clk, rst, $rose(out_ch.valid) |-> $past(state) == fsf_pkg::S_ALPHA, "result without alpha")
  `ASSERT_CLK(a_paused_loaded, clk, rst, paused |-> loaded, "paused without clip")
  `ASSERT_CLK(a_play_fin, clk, rst, playing |-> !finished, "playing and finished")
endmodule
`default_nettype wire

// ===== hdl/frame_sequencer_with_fade.sv =====
// Sequence: a command other than a tick passes from S_CMD through S_ALPHA to S_OUT;
// a tick passes the fade states while a fade runs, then S_RATE, then the scale, add,
// sum and step states while the clip advances, and S_MOD for a loop wrap that needs
// a remainder. Throughput: one command at a time; the next is taken the cycle after
// the result transfer. Reset: rst is synchronous, active high; the duration table
// is not cleared.
// ----------------------------------------------------------------------------
// frame_sequencer_with_fade: top level
// Frame sequencer with opacity fade built on one shared divider.
// ----------------------------------------------------------------------------
`default_nettype none
module frame_sequencer_with_fade (
  input  wire logic clk,
  input  wire logic rst,
  fsf_if.sink       in_ch,
  fsf_if.source     out_ch,
  fsf_if.sink       cfg
);
  fsf_pkg::div_req_t dreq;
  fsf_pkg::div_rsp_t drsp;

  fsf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg),
    .dreq(dreq), .drsp(drsp)
  );

  fsf_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));
endmodule
`default_nettype wire
